// ===== sv/slc_pkg.sv =====
// shared constants, types and codes for the lock set cam
package slc_pkg;

    localparam int CAPACITY    = 4;
    localparam int OTHER_SLOTS = 4;
    localparam int LOCK_W      = 64;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int OTH_CNT_W   = 3;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef logic [LOCK_W-1:0]             t_lock;
    typedef t_lock [OTHER_SLOTS-1:0]       t_other_set;
    typedef logic [CNT_W-1:0]              t_count;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_COMMON = 2'd2,
        KIND_SUBSET = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } t_status;

    // what one lane found for its stored entry
    typedef struct packed {
        logic id_hit;
        logic in_other;
    } t_lane_hit;

    typedef t_lane_hit [CAPACITY-1:0] t_lane_hits;

    // store update and result from the merge stage
    typedef struct packed {
        logic                add_en;
        logic [CAPACITY-1:0] shift;
        t_count              next_count;
        logic                answer;
        t_status             status;
    } t_merge_out;

endpackage

// ===== sv/slc_lane.sv =====
// one lane: compares a stored entry against the item's id and the other set
module slc_lane
    import slc_pkg::*;
(
    input  t_lock                  i_entry,
    input  t_lock                  i_lock_id,
    input  t_other_set             i_other,
    input  logic [OTHER_SLOTS-1:0] i_other_vld,
    output t_lane_hit              o_hit
);

    logic [OTHER_SLOTS-1:0] w_oth_eq;

    always_comb begin
        for (int j = 0; j < OTHER_SLOTS; j++) begin
            w_oth_eq[j] = i_other_vld[j] && (i_other[j] == i_entry);
        end
        o_hit.id_hit   = (i_entry == i_lock_id);
        o_hit.in_other = |w_oth_eq;
    end

endmodule

// ===== sv/slc_merge.sv =====
// merges lane results into the answer, status and store update
module slc_merge
    import slc_pkg::*;
(
    input  t_lane_hits        i_hits,
    input  t_count            i_count,
    input  logic [KIND_W-1:0] i_kind,
    output t_merge_out        o_res
);

    logic [CAPACITY-1:0] w_vld;
    logic [CAPACITY-1:0] w_id_hit;
    logic [CAPACITY-1:0] w_in_oth;
    logic [CAPACITY-1:0] w_after_hit;
    logic                w_full;
    logic                w_found;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_vld[i]    = (t_count'(i) < i_count);
            w_id_hit[i] = w_vld[i] && i_hits[i].id_hit;
            w_in_oth[i] = i_hits[i].in_other;
        end
        // entries above the first match move down one place, overwriting the matched entry
        w_after_hit[0] = w_id_hit[0];
        for (int i = 1; i < CAPACITY; i++) begin
            w_after_hit[i] = w_after_hit[i-1] || w_id_hit[i];
        end
        w_full  = (i_count >= t_count'(CAPACITY));
        w_found = |w_id_hit;
    end

    always_comb begin
        o_res.add_en     = 1'b0;
        o_res.shift      = '0;
        o_res.next_count = i_count;
        o_res.answer     = 1'b0;
        o_res.status     = ST_OK;
        case (t_kind'(i_kind))
            KIND_ADD: begin
                if (w_full) begin
                    o_res.status = ST_FULL;
                end else begin
                    o_res.add_en     = 1'b1;
                    o_res.next_count = i_count + t_count'(1);
                end
            end
            KIND_REMOVE: begin
                if (w_found) begin
                    o_res.shift      = w_after_hit;
                    o_res.next_count = i_count - t_count'(1);
                end else begin
                    o_res.status = ST_MISSING;
                end
            end
            KIND_COMMON: begin
                o_res.answer = |(w_vld & w_in_oth);
            end
            KIND_SUBSET: begin
                o_res.answer = &(~w_vld | w_in_oth);
            end
            default: begin
                o_res.answer = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/small_lockset_cam_top.sv =====
// a result is registered and appears in the cycle after its input transfer
// throughput: one item per cycle while results are taken; a held result blocks input
// every item is handled in the cycle of its transfer by one lane per stored entry
// reset clears the held count and the output valid; stored ids are not cleared
// top level: lock store, lanes, merge stage and output register
module small_lockset_cam_top
    import slc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [LOCK_W-1:0]     i_lock_id,
    input  logic [OTH_CNT_W-1:0]  i_other_count,
    input  logic [LOCK_W-1:0]     i_other_lock_0,
    input  logic [LOCK_W-1:0]     i_other_lock_1,
    input  logic [LOCK_W-1:0]     i_other_lock_2,
    input  logic [LOCK_W-1:0]     i_other_lock_3,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_answer,
    output logic [STATUS_W-1:0]   o_status,
    output logic [CNT_W-1:0]      o_held_count
);

    t_lock                  r_store [CAPACITY];
    t_lock                  n_store [CAPACITY];
    t_lock                  w_up    [CAPACITY];
    t_count                 r_count;
    logic                   r_out_valid;
    logic                   r_answer;
    t_status                r_status;
    t_count                 r_held;
    logic                   w_in_acc;
    t_other_set             w_other;
    logic [OTHER_SLOTS-1:0] w_other_vld;
    t_lane_hits             w_hits;
    t_merge_out             w_res;

    assign o_stall  = r_out_valid && i_stall;
    assign w_in_acc = i_valid && !o_stall;

    assign w_other[0] = i_other_lock_0;
    assign w_other[1] = i_other_lock_1;
    assign w_other[2] = i_other_lock_2;
    assign w_other[3] = i_other_lock_3;

    // a count above the slot number simply makes every slot valid
    always_comb begin
        for (int j = 0; j < OTHER_SLOTS; j++) begin
            w_other_vld[j] = (i_other_count > OTH_CNT_W'(j));
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_lane
        slc_lane u_lane (
            .i_entry     (r_store[g]),
            .i_lock_id   (i_lock_id),
            .i_other     (w_other),
            .i_other_vld (w_other_vld),
            .o_hit       (w_hits[g])
        );
        if (g < CAPACITY - 1) begin : g_up
            assign w_up[g] = r_store[g+1];
        end else begin : g_last
            assign w_up[g] = r_store[g];
        end
    end

    slc_merge u_merge (
        .i_hits  (w_hits),
        .i_count (r_count),
        .i_kind  (i_kind),
        .o_res   (w_res)
    );

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_store[i] = w_res.shift[i] ? w_up[i] : r_store[i];
            if (w_res.add_en && (r_count[IDX_W-1:0] == IDX_W'(i))) begin
                n_store[i] = i_lock_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_count     <= w_res.next_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_store  <= n_store;
            r_answer <= w_res.answer;
            r_status <= w_res.status;
            r_held   <= w_res.next_count;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_answer     = r_answer;
    assign o_status     = r_status;
    assign o_held_count = r_held;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(CAPACITY))
        else $error("held count above capacity");

    a_full_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_kind == KIND_ADD) && (r_count == t_count'(CAPACITY))
        |=> (r_status == ST_FULL) && $stable(r_count))
        else $error("add to full set changed the set");

    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_kind == KIND_REMOVE)
        |=> (r_status == ST_MISSING) == (r_count == $past(r_count)))
        else $error("remove status and count disagree");

    a_held_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_held == r_count))
        else $error("reported count differs from held count");
`endif

endmodule
